// ----- sv/mwsg_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-waveform sample generator package
// Default sizes, widths, register indexes, waveform codes, reset values and
// the sine series constants shared by the generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsg_pkg;

   // Default sizes of the table period and the quarter-wave sine ROM.
   localparam int unsigned DEF_TABLE_LENGTH   = 400;
   localparam int unsigned DEF_SINE_ROM_DEPTH = 256;

   // Payload widths fixed by the interface.
   localparam int unsigned AMP_W    = 12;
   localparam int unsigned STEP_W   = 32;
   localparam int unsigned SEL_W    = 2;
   localparam int unsigned CODE_W   = 12;
   localparam int unsigned POS_W    = 9;
   localparam int unsigned CSR_IX_W = 2;
   localparam int unsigned CSR_DW   = 32;

   // Offset wave value: 32768 + v, range 0 to 65536.
   localparam int unsigned WAVE_W = 17;

   // Configuration register indexes.
   localparam logic [CSR_IX_W-1:0] CSR_AMPLITUDE = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_STEP      = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_WAVE      = 2'd2;

   // Waveform codes.
   localparam logic [SEL_W-1:0] WAVE_SINE     = 2'd0;
   localparam logic [SEL_W-1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [SEL_W-1:0] WAVE_TRIANGLE = 2'd2;
   localparam logic [SEL_W-1:0] WAVE_SAWTOOTH = 2'd3;

   // Register reset values.
   localparam logic [AMP_W-1:0]  RST_AMPLITUDE = 12'd1240;
   localparam logic [STEP_W-1:0] RST_STEP      = 32'd10737418;
   localparam logic [SEL_W-1:0]  RST_WAVE      = WAVE_SINE;

   // Sine series in Q30: pi/2, one, and the divisors (2n)(2n+1) of its terms.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam int unsigned SERIES_TERMS = 9;
   localparam logic [63:0] SERIES_DIV [SERIES_TERMS] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};

endpackage

`default_nettype wire

// ----- sv/multi_waveform_sample_generator.sv -----
// ----------------------------------------------------------------------------
// Multi-waveform sample generator
// Direct digital synthesis of sine, square, triangle and sawtooth DAC samples.
// ----------------------------------------------------------------------------
// The generator takes one item per clock cycle while req_tready is high and
// returns one 12-bit DAC sample for each. The items pass in order through a
// three-stage pipeline (phase capture, waveform lookup, amplitude multiply);
// each stage holds while the stage after it is full and stalled, and the
// input stalls in turn. Sample n of a table period has phase
// n * phase_step as a 0.32 fraction of a cycle, and both restart at zero after
// the last sample of the period or when an item carries restart. The sample is
// amplitude_code * (1 + w), saturated to 4095, where w runs from -1 to +1. The
// sine comes from a quarter-wave table of SINE_ROM_DEPTH + 1 entries, built at
// elaboration, so no clearing pass or fill is needed after reset. Configuration
// must be written through csr while no item is in flight; nothing checks it.
`default_nettype none

module multi_waveform_sample_generator
   import mwsg_pkg::*;
#(
   parameter int unsigned TABLE_LENGTH   = DEF_TABLE_LENGTH,
   parameter int unsigned SINE_ROM_DEPTH = DEF_SINE_ROM_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Input items.
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [7:0]          req_tdata,   // [0] restart, [7:1] zero
   // Result items.
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [23:0]         rsp_tdata,   // [11:0] sample_code,
                                                 // [20:12] table_position,
                                                 // [23:21] zero
   output      logic                rsp_tlast,   // period_end
   // Configuration writes.
   input  wire logic                csr_wr_en,
   input  wire logic [CSR_IX_W-1:0] csr_index,
   input  wire logic [CSR_DW-1:0]   csr_wdata
);

   localparam int unsigned IDX_W  = (TABLE_LENGTH > 2) ? $clog2(TABLE_LENGTH) : 1;
   localparam int unsigned ROM_AW = $clog2(SINE_ROM_DEPTH + 1);
   localparam int unsigned PROD_W = 30 + ROM_AW;
   localparam int unsigned MUL_W  = AMP_W + WAVE_W;

   localparam logic [IDX_W-1:0]  LAST_INDEX = IDX_W'(TABLE_LENGTH - 1);
   localparam logic [ROM_AW-1:0] ROM_TOP    = ROM_AW'(SINE_ROM_DEPTH);
   localparam logic [WAVE_W-1:0] WAVE_MID   = WAVE_W'(32768);
   localparam logic [WAVE_W-1:0] WAVE_TOP   = WAVE_W'(65536);
   localparam logic [WAVE_W:0]   TRI_TOP    = (WAVE_W + 1)'(131072);

   // Quarter-wave sine entry k, round(32768 * sin(pi/2 * k / SINE_ROM_DEPTH)),
   // evaluated with the Q30 Taylor series.
   function automatic logic [WAVE_W-1:0] sine_entry(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_ROM_DEPTH);
      term = x;
      sum  = signed'(x);
      for (int n = 0; n < SERIES_TERMS; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / SERIES_DIV[n];
         if ((n % 2) == 0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (unsigned'(sum) > Q30_ONE) begin
         sum = signed'(Q30_ONE);
      end
      r = ((unsigned'(sum) * 64'd32768) + (Q30_ONE >> 1)) >> 30;
      return r[WAVE_W-1:0];
   endfunction

   logic [WAVE_W-1:0] sine_rom [SINE_ROM_DEPTH+1];

   for (genvar k = 0; k <= SINE_ROM_DEPTH; k++) begin : g_rom
      assign sine_rom[k] = sine_entry(k);
   end

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [AMP_W-1:0]  amp_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SEL_W-1:0]  sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff  <= RST_AMPLITUDE;
         step_ff <= RST_STEP;
         sel_ff  <= RST_WAVE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_AMPLITUDE: amp_ff  <= csr_wdata[AMP_W-1:0];
            CSR_STEP:      step_ff <= csr_wdata[STEP_W-1:0];
            CSR_WAVE:      sel_ff  <= csr_wdata[SEL_W-1:0];
            default: begin
               // Writes to an unused index are dropped.
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Pipeline flow control: a stage moves when the stage after it is empty
   // or moving itself.
   // -------------------------------------------------------------------------
   logic s1_vld_ff;
   logic s2_vld_ff;
   logic rsp_vld_ff;
   logic move1;
   logic move2;
   logic move3;
   logic req_accept;

   assign move3      = !rsp_vld_ff || rsp_tready;
   assign move2      = !s2_vld_ff || move3;
   assign move1      = !s1_vld_ff || move2;
   assign req_tready = move1;
   assign req_accept = req_tvalid && move1;

   // -------------------------------------------------------------------------
   // Phase and table position. A restart takes effect before this sample.
   // -------------------------------------------------------------------------
   logic [IDX_W-1:0]  idx_ff;
   logic [STEP_W-1:0] phase_ff;
   logic [IDX_W-1:0]  cur_idx;
   logic [STEP_W-1:0] cur_phase;
   logic              cur_last;

   assign cur_idx   = req_tdata[0] ? '0 : idx_ff;
   assign cur_phase = req_tdata[0] ? '0 : phase_ff;
   assign cur_last  = (cur_idx >= LAST_INDEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         phase_ff <= '0;
      end else if (req_accept) begin
         if (cur_last) begin
            idx_ff   <= '0;
            phase_ff <= '0;
         end else begin
            idx_ff   <= cur_idx + IDX_W'(1);
            phase_ff <= cur_phase + step_ff;
         end
      end
   end

   // Stage 1: phase, position and a snapshot of the configuration.
   logic [STEP_W-1:0] s1_phase_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic              s1_last_ff;
   logic [AMP_W-1:0]  s1_amp_ff;
   logic [SEL_W-1:0]  s1_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (move1) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_phase_ff <= cur_phase;
         s1_idx_ff   <= cur_idx;
         s1_last_ff  <= cur_last;
         s1_amp_ff   <= amp_ff;
         s1_sel_ff   <= sel_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: waveform value, kept offset by one as u = 32768 * (1 + w).
   // -------------------------------------------------------------------------
   logic [1:0]        quad;
   logic [PROD_W-1:0] sin_prod;
   logic [ROM_AW-1:0] sin_addr;
   logic [ROM_AW-1:0] rom_ix;
   logic [WAVE_W-1:0] sin_mag;
   logic [WAVE_W:0]   tri_raw;
   logic [WAVE_W-1:0] wave_in;

   assign quad     = s1_phase_ff[31:30];
   assign sin_prod = PROD_W'(s1_phase_ff[29:0]) * PROD_W'(SINE_ROM_DEPTH);
   assign sin_addr = sin_prod[PROD_W-1:30];
   assign rom_ix   = quad[0] ? (ROM_TOP - sin_addr) : sin_addr;
   assign sin_mag  = sine_rom[rom_ix];
   assign tri_raw  = (WAVE_W + 1)'(s1_phase_ff[31:15]);

   always_comb begin
      case (s1_sel_ff)
         WAVE_SINE: begin
            wave_in = quad[1] ? (WAVE_MID - sin_mag) : (WAVE_MID + sin_mag);
         end
         WAVE_SQUARE: begin
            // High only strictly inside the first half cycle.
            wave_in = ((s1_phase_ff != '0) && !s1_phase_ff[31]) ? WAVE_TOP : '0;
         end
         WAVE_TRIANGLE: begin
            if (!s1_phase_ff[31]) begin
               wave_in = tri_raw[WAVE_W-1:0];
            end else begin
               wave_in = WAVE_W'(TRI_TOP - tri_raw);
            end
         end
         WAVE_SAWTOOTH: wave_in = WAVE_W'(s1_phase_ff[31:16]);
         default:       wave_in = WAVE_MID;
      endcase
   end

   logic [WAVE_W-1:0] s2_wave_ff;
   logic [AMP_W-1:0]  s2_amp_ff;
   logic [POS_W-1:0]  s2_pos_ff;
   logic              s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (move2) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move2 && s1_vld_ff) begin
         s2_wave_ff <= wave_in;
         s2_amp_ff  <= s1_amp_ff;
         s2_pos_ff  <= POS_W'(s1_idx_ff);
         s2_last_ff <= s1_last_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 3: scale by the amplitude, drop the 15 fraction bits, saturate.
   // -------------------------------------------------------------------------
   logic [MUL_W-1:0]    scaled;
   logic [MUL_W-16:0]   code_wide;
   logic [CODE_W-1:0]   code_in;

   assign scaled    = MUL_W'(s2_amp_ff) * MUL_W'(s2_wave_ff);
   assign code_wide = scaled[MUL_W-1:15];
   assign code_in   = (|code_wide[MUL_W-16:CODE_W]) ? '1 : code_wide[CODE_W-1:0];

   logic [CODE_W-1:0] rsp_code_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (move3) begin
         rsp_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move3 && s2_vld_ff) begin
         rsp_code_ff <= code_in;
         rsp_pos_ff  <= s2_pos_ff;
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_pos_ff, rsp_code_ff};
   assign rsp_tlast  = rsp_last_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_wrap_clears_state : assert property (@(posedge clock) disable iff (reset)
      (req_accept && cur_last) |=> (idx_ff == '0) && (phase_ff == '0))
      else $error("table state not cleared after the last sample of a period");

   a_restart_at_zero : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tdata[0]) |=> (s1_idx_ff == '0) && (s1_phase_ff == '0))
      else $error("restart did not start at table position zero");

   a_last_position : assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_last_ff) |-> (rsp_pos_ff == POS_W'(TABLE_LENGTH - 1)))
      else $error("period end flagged away from the last table position");

   a_square_levels : assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && (s1_sel_ff == WAVE_SQUARE))
         |-> ((wave_in == '0) || (wave_in == WAVE_TOP)))
      else $error("square wave value is not at a rail");

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_INDEX)
      else $error("table index beyond the period");

endmodule

`default_nettype wire

// ----- sim/multi_waveform_sample_generator_test.sv -----
// ----------------------------------------------------------------------------
// Multi-waveform sample generator testbench
// Drives restart items into the generator and checks every DAC sample, table
// position and period flag against a cycle-free predictor of the generator,
// under directed corner cases, random settings and random flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_waveform_sample_generator_test;
   import mwsg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The pipeline is three stages deep; a few spare cycles are added to it
   // whenever the testbench waits for the block to settle.
   localparam int unsigned PIPE_LATENCY = 3;
   localparam int unsigned SETTLE_CYCLES = PIPE_LATENCY + 4;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned TABLE_LAST = DEF_TABLE_LENGTH - 1;

   // Index 3 decodes to no register; writes to it must be dropped.
   localparam logic [CSR_IX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic [SEL_W-1:0] WAVE_CODES [4] =
      '{WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE, WAVE_SAWTOOTH};

   // One predicted result item.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [POS_W-1:0]  position;
      logic              period_end;
   } sample_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [23:0]         rsp_tdata;
   logic                rsp_tlast;
   logic                csr_wr_en;
   logic [CSR_IX_W-1:0] csr_index;
   logic [CSR_DW-1:0]   csr_wdata;

   // Predictor copy of the registers and of the generator state.
   logic [AMP_W-1:0]  cfg_amplitude;
   logic [STEP_W-1:0] cfg_step;
   logic [SEL_W-1:0]  cfg_wave;
   logic [POS_W-1:0]  gen_position;
   logic [31:0]       gen_phase;

   sample_type  expected_samples [$];
   int unsigned mismatch_count;
   int unsigned cycle_count;

   // Flow control knobs set by the test tasks; the stall knob is in percent.
   int unsigned rsp_stall_pct;
   int unsigned hold_request;
   int unsigned hold_left;

   multi_waveform_sample_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Quarter-wave table entry k as a Q15 value, from the Taylor series of the
   // sine evaluated in Q30 with nine correction terms.
   function automatic int quarter_sine(int unsigned k);
      longint unsigned x;
      longint unsigned term;
      longint unsigned rounded;
      longint          sum;
      x = (HALF_PI_Q30 * 64'(k)) / 64'(DEF_SINE_ROM_DEPTH);
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 9; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum -= longint'(term);
         end else begin
            sum += longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > longint'(Q30_ONE)) begin
         sum = longint'(Q30_ONE);
      end
      rounded = (longint'(sum) * 32768 + longint'(Q30_ONE >> 1)) >> 30;
      return int'(rounded);
   endfunction

   // Wave value in Q15, -32768 to +32768, for a 0.32 phase.
   function automatic int wave_value(logic [31:0] phase, logic [SEL_W-1:0] sel);
      logic [1:0]      quad;
      longint unsigned addr;
      int              mag;
      case (sel)
         WAVE_SINE: begin
            quad = phase[31:30];
            addr = (64'(phase[29:0]) * 64'(DEF_SINE_ROM_DEPTH)) >> 30;
            if (quad[0]) begin
               mag = quarter_sine(DEF_SINE_ROM_DEPTH - int'(addr));
            end else begin
               mag = quarter_sine(int'(addr));
            end
            return quad[1] ? -mag : mag;
         end
         WAVE_SQUARE: begin
            // High only strictly inside the first half cycle.
            return (phase != 0 && phase < 32'h8000_0000) ? 32768 : -32768;
         end
         WAVE_TRIANGLE: begin
            if (phase < 32'h8000_0000) begin
               return int'(phase >> 15) - 32768;
            end
            return 98304 - int'(phase >> 15);
         end
         default: begin
            return int'(phase >> 16) - 32768;
         end
      endcase
   endfunction

   // Works out the sample for one accepted item and advances the state.
   function automatic sample_type next_sample(logic restart);
      sample_type s;
      longint     acc;
      int         v;
      if (restart) begin
         gen_position = '0;
         gen_phase = '0;
      end
      v = wave_value(gen_phase, cfg_wave);
      acc = longint'(cfg_amplitude) * 32768 + longint'(cfg_amplitude) * longint'(v);
      if (acc < 0) begin
         acc = 0;
      end
      acc = acc >>> 15;
      if (acc > 4095) begin
         acc = 4095;
      end
      s.code = acc[CODE_W-1:0];
      s.position = gen_position;
      s.period_end = (gen_position >= TABLE_LAST);
      if (s.period_end) begin
         gen_position = '0;
         gen_phase = '0;
      end else begin
         gen_position = gen_position + 1'b1;
         gen_phase = gen_phase + cfg_step;
      end
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random stalls, long hold-offs and the checker
   // ------------------------------------------------------------------------

   // A hold-off request from a test is taken over here and counted down one
   // cycle at a time; otherwise ready follows the current stall percentage.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Every accepted result item is matched against the oldest prediction.
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected result item: code %0d position %0d last %0b",
                     $time, rsp_tdata[11:0], rsp_tdata[20:12], rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata[11:0] !== want.code) begin
               $display("%0t: sample_code expected %0d actual %0d",
                        $time, want.code, rsp_tdata[11:0]);
               mismatch_count++;
            end
            if (rsp_tdata[20:12] !== want.position) begin
               $display("%0t: table_position expected %0d actual %0d",
                        $time, want.position, rsp_tdata[20:12]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.period_end) begin
               $display("%0t: period_end expected %0b actual %0b",
                        $time, want.period_end, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tdata[23:21] !== 3'b000) begin
               $display("%0t: rsp_tdata pad expected 0 actual %0h",
                        $time, rsp_tdata[23:21]);
               mismatch_count++;
            end
         end
      end
   end

   // A hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("multi_waveform_sample_generator_test NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Shared stimulus tasks
   // ------------------------------------------------------------------------

   // Offers one item, optionally after a random idle gap, and records its
   // prediction once the block takes it. Valid stays high on return so that
   // back-to-back items need no extra edge.
   task automatic send_item(input logic restart, input int unsigned idle_pct);
      int unsigned gap;
      gap = 0;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 60) begin
         gap++;
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, restart};
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      expected_samples.push_back(next_sample(restart));
   endtask

   // Stops offering items and waits until every predicted result has arrived
   // and the pipeline has had time to empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write. The predictor keeps only the register's own width,
   // and an index with no register behind it changes nothing.
   task automatic write_reg(input logic [CSR_IX_W-1:0] index, input logic [CSR_DW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_AMPLITUDE: cfg_amplitude = value[AMP_W-1:0];
         CSR_STEP:      cfg_step = value[STEP_W-1:0];
         CSR_WAVE:      cfg_wave = value[SEL_W-1:0];
         default:       ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Writes all registers with random settings, the extremes among them. The
   // unused high bits of the narrow registers carry random junk.
   task automatic randomize_config();
      logic [AMP_W-1:0]  amp;
      logic [STEP_W-1:0] step;
      case ($urandom_range(3))
         0:       amp = '0;
         1:       amp = '1;
         default: amp = AMP_W'($urandom);
      endcase
      case ($urandom_range(4))
         0:       step = '0;
         1:       step = '1;
         2:       step = STEP_W'($urandom_range(20000000));
         default: step = $urandom;
      endcase
      write_reg(CSR_AMPLITUDE, {$urandom} & ~32'hFFF | 32'(amp));
      write_reg(CSR_STEP, step);
      write_reg(CSR_WAVE, {$urandom} & ~32'h3 | 32'($urandom_range(3)));
      if ($urandom_range(1) == 0) begin
         write_reg(CSR_UNUSED, $urandom);
      end
   endtask

   // A run of items under one setting. A restart comes with odds of one in
   // restart_odds; zero odds means the run flows through whole periods.
   task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                            input int unsigned restart_odds, input logic lead_restart);
      logic restart;
      for (int i = 0; i < count; i++) begin
         restart = (i == 0) && lead_restart;
         if (restart_odds != 0 && $urandom_range(restart_odds - 1) == 0) begin
            restart = 1'b1;
         end
         send_item(restart, idle_pct);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset settings, then each waveform at full amplitude stepped by a
   // quarter cycle so the samples land on the quadrant boundaries: the
   // square's zero phase, the sine's peaks and saturation at 4095. Last come
   // zero amplitude with the largest step and a write to the unused index.
   task automatic test_directed();
      rsp_stall_pct = 0;
      send_item(1'b0, 0);
      send_item(1'b0, 0);
      send_item(1'b1, 0);
      settle();
      foreach (WAVE_CODES[w]) begin
         write_reg(CSR_WAVE, {$urandom} & ~32'h3 | 32'(WAVE_CODES[w]));
         write_reg(CSR_AMPLITUDE, 32'hFFFF_FFFF);
         write_reg(CSR_STEP, 32'h4000_0000);
         send_item(1'b1, 0);
         repeat (4) send_item(1'b0, 0);
         settle();
      end
      write_reg(CSR_AMPLITUDE, 32'h0000_F000);
      write_reg(CSR_STEP, 32'hFFFF_FFFF);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      send_item(1'b1, 0);
      send_item(1'b0, 0);
      settle();
   endtask

   // Random settings under each flow-control pattern. The first run goes
   // through a whole table period so the period flag and the wrap of the
   // position and phase are seen; the later ones restart now and then.
   task automatic test_random_phases();
      randomize_config();
      rsp_stall_pct = 0;
      run_phase(405, 0, 0, 1'b1);
      settle();

      randomize_config();
      rsp_stall_pct = 0;
      run_phase(40, 85, 16, 1'b0);
      settle();

      randomize_config();
      rsp_stall_pct = 85;
      run_phase(40, 0, 16, 1'b0);
      settle();

      randomize_config();
      rsp_stall_pct = 30;
      run_phase(40, 30, 16, 1'b0);
      settle();
   endtask

   // The receiver holds off for a long stretch while items keep coming, so
   // the pipeline fills and the input stalls. Then the sender waits until
   // every result is out before going on under the same setting.
   task automatic test_backpressure();
      randomize_config();
      rsp_stall_pct = 0;
      hold_request = 300;
      run_phase(40, 0, 0, 1'b0);
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(posedge clock);
      end
      rsp_stall_pct = 30;
      run_phase(20, 30, 8, 1'b0);
      settle();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      rsp_stall_pct = 0;
      hold_request = 0;
      hold_left = 0;
      cfg_amplitude = RST_AMPLITUDE;
      cfg_step = RST_STEP;
      cfg_wave = RST_WAVE;
      gen_position = '0;
      gen_phase = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phases();
      test_backpressure();

      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("multi_waveform_sample_generator_test OK");
      end else begin
         $display("multi_waveform_sample_generator_test NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- multi_waveform_sample_generator.f -----
sv/mwsg_pkg.sv
sv/multi_waveform_sample_generator.sv
sim/multi_waveform_sample_generator_test.sv
